@@ rtl/yuyv565_pkg.sv @@
// Shared constants, types and pipeline enables for the YUYV pair to RGB565 converter.
`timescale 1ns / 1ps

package yuyv565_pkg;

    // BT.601 integer coefficients, rounding term and luma input offset.
    localparam int COEF_Y      = 298;
    localparam int COEF_CR_B   = 409;
    localparam int COEF_CB_G   = 100;
    localparam int COEF_CR_G   = 208;
    localparam int COEF_CB_R   = 516;
    localparam int ROUND_ADD   = 128;
    localparam int LUMA_OFFSET = 16;

    // Byte widths of the stream payloads.
    localparam int IN_BYTES  = 4;
    localparam int OUT_BYTES = 4;

    // Offset luma spans -16..239, offset chroma -128..127.
    typedef logic signed [8:0]  luma_t;
    typedef logic signed [7:0]  chroma_t;
    // Any single product fits in 19 signed bits, any channel sum in 20.
    typedef logic signed [18:0] prod_t;
    typedef logic signed [19:0] sum_t;

    // Load enables of the register stages behind the input stage.
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

endpackage

@@ rtl/yuyv565_pixel.sv @@
// Luma product, channel sums, clamping and RGB565 packing for one output pixel.
`timescale 1ns / 1ps

module yuyv565_pixel
    import yuyv565_pkg::*;
(
    input  logic      aclk,
    input  stage_en_t en,
    input  luma_t     luma,      // stage 1 register, offset luma
    input  prod_t     prod_cr_b, // stage 2 registers, chroma products
    input  prod_t     prod_cb_g,
    input  prod_t     prod_cr_g,
    input  prod_t     prod_cb_r,
    output logic [7:0] low_byte,
    output logic [7:0] high_byte
);

    // Floor of sum / 256, clamped to 0..255.
    function automatic logic [7:0] sat8(input sum_t s);
        logic signed [11:0] q;
        q = s[19:8];
        if (q[11]) begin
            return 8'd0;
        end else if (q[10:8] != 3'd0) begin
            return 8'hff;
        end else begin
            return q[7:0];
        end
    endfunction

    prod_t      yy_reg, yy_next;
    sum_t       sum_b_reg, sum_g_reg, sum_r_reg;
    sum_t       sum_b_next, sum_g_next, sum_r_next;
    logic [7:0] low_reg, high_reg, low_next, high_next;
    logic [7:0] chan_b, chan_g, chan_r;

    // Stage 2: scaled luma.
    assign yy_next = prod_t'(luma) * prod_t'(COEF_Y);

    // Stage 3: channel sums with the rounding term.
    assign sum_b_next = sum_t'(yy_reg) + sum_t'(prod_cr_b) + sum_t'(ROUND_ADD);
    assign sum_g_next = sum_t'(yy_reg) - sum_t'(prod_cb_g) - sum_t'(prod_cr_g)
                      + sum_t'(ROUND_ADD);
    assign sum_r_next = sum_t'(yy_reg) + sum_t'(prod_cb_r) + sum_t'(ROUND_ADD);

    // Stage 4: clamp each channel and pack into two bytes.
    assign chan_b    = sat8(sum_b_reg);
    assign chan_g    = sat8(sum_g_reg);
    assign chan_r    = sat8(sum_r_reg);
    assign low_next  = {chan_g[4:2], chan_b[7:3]};
    assign high_next = {chan_r[7:3], chan_g[7:5]};

    // Payload registers, loaded when their stage advances.
    always_ff @(posedge aclk) begin
        if (en.s2) begin
            yy_reg <= yy_next;
        end
        if (en.s3) begin
            sum_b_reg <= sum_b_next;
            sum_g_reg <= sum_g_next;
            sum_r_reg <= sum_r_next;
        end
        if (en.s4) begin
            low_reg  <= low_next;
            high_reg <= high_next;
        end
    end

    assign low_byte  = low_reg;
    assign high_byte = high_reg;

endmodule

@@ rtl/yuyv_pair_to_rgb565.sv @@
// Top level: four-stage pipeline converting one YUYV pixel pair to two RGB565 pixels.
//
//  Channel | Direction | Ports                               | Contents
//  --------+-----------+-------------------------------------+----------------------------
//  s_      | in        | s_tvalid s_tready s_tdata s_tlast   | one packed 4:2:2 pixel pair
//  m_      | out       | m_tvalid m_tready m_tdata m_tlast   | two RGB565 pixels
//
// One item enters per clock unless a stall at m_tready has backed up to stage 1; its result
// raises m_tvalid after the four register stages (offset, multiply, sum, clamp and pack).
// Reset clears only the stage valid bits; the payload registers are not reset.
// A stage holds its item while the stage after it is full and stalled, so a stall
// at m_tready backs up stage by stage and empty stages still accept new items.
`timescale 1ns / 1ps

module yuyv_pair_to_rgb565
    import yuyv565_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // luma_second [7:0], chroma_cr [15:8], luma_first [23:16], chroma_cb [31:24]
    input  logic [8*IN_BYTES-1:0]    s_tdata,
    input  logic                     s_tlast,   // last_pair
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // first_low_byte [7:0], first_high_byte [15:8],
    // second_low_byte [23:16], second_high_byte [31:24]
    output logic [8*OUT_BYTES-1:0]   m_tdata,
    output logic                     m_tlast    // end_of_frame
);

    logic      v1_reg, v2_reg, v3_reg, v4_reg;
    logic      adv1, adv2, adv3, adv4;
    stage_en_t en;

    luma_t     y1_reg, y2_reg, y1_next, y2_next;
    chroma_t   cr_reg, cb_reg, cr_next, cb_next;
    logic      last1_reg, last2_reg, last3_reg, last4_reg;

    prod_t     cr_b_reg, cb_g_reg, cr_g_reg, cb_r_reg;
    prod_t     cr_b_next, cb_g_next, cr_g_next, cb_r_next;

    logic [7:0] first_low, first_high, second_low, second_high;

    // A stage advances when it is empty or the stage after it advances.
    assign adv4     = !v4_reg || m_tready;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;
    assign en       = '{s2: adv2, s3: adv3, s4: adv4};

    // Valid bits travel with the items.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_tvalid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    // Stage 1: remove the luma and chroma offsets.
    assign y2_next = $signed({1'b0, s_tdata[7:0]}) - luma_t'(LUMA_OFFSET);
    assign cr_next = $signed({~s_tdata[15], s_tdata[14:8]});
    assign y1_next = $signed({1'b0, s_tdata[23:16]}) - luma_t'(LUMA_OFFSET);
    assign cb_next = $signed({~s_tdata[31], s_tdata[30:24]});

    // Stage 2: chroma products, shared by both pixels.
    assign cr_b_next = prod_t'(cr_reg) * prod_t'(COEF_CR_B);
    assign cb_g_next = prod_t'(cb_reg) * prod_t'(COEF_CB_G);
    assign cr_g_next = prod_t'(cr_reg) * prod_t'(COEF_CR_G);
    assign cb_r_next = prod_t'(cb_reg) * prod_t'(COEF_CB_R);

    // Payload registers of the shared path and the frame flag.
    always_ff @(posedge aclk) begin
        if (adv1) begin
            y1_reg    <= y1_next;
            y2_reg    <= y2_next;
            cr_reg    <= cr_next;
            cb_reg    <= cb_next;
            last1_reg <= s_tlast;
        end
        if (adv2) begin
            cr_b_reg  <= cr_b_next;
            cb_g_reg  <= cb_g_next;
            cr_g_reg  <= cr_g_next;
            cb_r_reg  <= cb_r_next;
            last2_reg <= last1_reg;
        end
        if (adv3) begin
            last3_reg <= last2_reg;
        end
        if (adv4) begin
            last4_reg <= last3_reg;
        end
    end

    // Per-pixel datapaths for stages 2 to 4.
    yuyv565_pixel u_pixel_first (
        .aclk      (aclk),
        .en        (en),
        .luma      (y1_reg),
        .prod_cr_b (cr_b_reg),
        .prod_cb_g (cb_g_reg),
        .prod_cr_g (cr_g_reg),
        .prod_cb_r (cb_r_reg),
        .low_byte  (first_low),
        .high_byte (first_high)
    );

    yuyv565_pixel u_pixel_second (
        .aclk      (aclk),
        .en        (en),
        .luma      (y2_reg),
        .prod_cr_b (cr_b_reg),
        .prod_cb_g (cb_g_reg),
        .prod_cr_g (cr_g_reg),
        .prod_cb_r (cb_r_reg),
        .low_byte  (second_low),
        .high_byte (second_high)
    );

    // Result channel.
    assign m_tvalid = v4_reg;
    assign m_tdata  = {second_high, second_low, first_high, first_low};
    assign m_tlast  = last4_reg;

endmodule

@@ tb/rgb565_pair_checker.sv @@
// Checker for the YUYV pair to RGB565 converter: predicts each pixel pair and compares results.
`timescale 1ns / 1ps

module rgb565_pair_checker
    import yuyv565_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // luma_second [7:0], chroma_cr [15:8], luma_first [23:16], chroma_cb [31:24]
    input  logic [31:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // first_low_byte [7:0], first_high_byte [15:8],
    // second_low_byte [23:16], second_high_byte [31:24]
    input  logic [31:0] m_tdata,
    input  logic        m_tlast,
    output int          waiting,
    output int          mismatches
);

    localparam int CHROMA_OFFSET = 128;

    typedef struct packed {
        logic [31:0] pixels;
        logic        frame_end;
    } rgb_pair_t;

    rgb_pair_t pending_pixels[$];

    string byte_name [4] = '{"first_low_byte", "first_high_byte",
                             "second_low_byte", "second_high_byte"};

    // Floor division by 256 followed by a clamp to the 8-bit channel range.
    function automatic logic [7:0] clamp_channel(input int sum);
        int q;
        q = sum >>> 8;
        if (q < 0) begin
            return 8'd0;
        end
        if (q > 255) begin
            return 8'd255;
        end
        return q[7:0];
    endfunction

    // One RGB565 pixel as {high byte, low byte}; blue takes cr and red takes cb.
    function automatic logic [15:0] rgb565_pixel(input int y, input int cb, input int cr);
        int          yy;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        yy = COEF_Y * y;
        b  = clamp_channel(yy + COEF_CR_B * cr + ROUND_ADD);
        g  = clamp_channel(yy - COEF_CB_G * cb - COEF_CR_G * cr + ROUND_ADD);
        r  = clamp_channel(yy + COEF_CB_R * cb + ROUND_ADD);
        return {r[7:3], g[7:5], g[4:2], b[7:3]};
    endfunction

    // Both pixels of a pair share the chroma samples.
    function automatic logic [31:0] yuyv_to_rgb565_pair(input logic [31:0] pair);
        int y_second;
        int cr;
        int y_first;
        int cb;
        y_second = int'(pair[7:0]) - LUMA_OFFSET;
        cr       = int'(pair[15:8]) - CHROMA_OFFSET;
        y_first  = int'(pair[23:16]) - LUMA_OFFSET;
        cb       = int'(pair[31:24]) - CHROMA_OFFSET;
        return {rgb565_pixel(y_second, cb, cr), rgb565_pixel(y_first, cb, cr)};
    endfunction

    // Record each accepted item and check each accepted result against the oldest one.
    always @(posedge aclk) begin
        rgb_pair_t want;
        int        errs;
        errs = 0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                pending_pixels.push_back('{yuyv_to_rgb565_pair(s_tdata), s_tlast});
            end
            if (m_tvalid && m_tready) begin
                if (pending_pixels.size() == 0) begin
                    $display("%0t: unexpected result data=%h last=%b", $time, m_tdata, m_tlast);
                    errs++;
                end else begin
                    want = pending_pixels.pop_front();
                    for (int i = 0; i < 4; i++) begin
                        if (m_tdata[8*i +: 8] !== want.pixels[8*i +: 8]) begin
                            $display("%0t: %s expected %h actual %h", $time, byte_name[i],
                                     want.pixels[8*i +: 8], m_tdata[8*i +: 8]);
                            errs++;
                        end
                    end
                    if (m_tlast !== want.frame_end) begin
                        $display("%0t: end_of_frame expected %b actual %b", $time,
                                 want.frame_end, m_tlast);
                        errs++;
                    end
                end
            end
        end
        waiting    <= pending_pixels.size();
        mismatches <= mismatches + errs;
    end

endmodule

@@ tb/tb.sv @@
// Testbench top: drives pixel pairs and output back-pressure into the converter and reports.
`timescale 1ns / 1ps

module tb;

    localparam int RANDOM_PAIRS = 700;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    int          waiting;
    int          mismatches;
    bit          sender_gaps;

    yuyv_pair_to_rgb565 dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    rgb565_pair_checker pair_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .waiting    (waiting),
        .mismatches (mismatches)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard limit on the run length.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("TB_ERROR");
        $finish;
    end

    // Byte order on the bus: second luma, cr, first luma, cb from the lowest byte up.
    function automatic logic [31:0] pair_word(input logic [7:0] y_second, input logic [7:0] cr,
                                              input logic [7:0] y_first, input logic [7:0] cb);
        return {cb, y_first, cr, y_second};
    endfunction

    // Offer one item, with random idle cycles before it when gaps are enabled.
    task automatic send_pair(input logic [31:0] pair, input logic last);
        while (sender_gaps && $urandom_range(99) < 27) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            s_tlast  <= 1'($urandom_range(1));
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= pair;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Let the pipeline empty out completely.
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (waiting != 0) @(posedge aclk);
    endtask

    // Receiver: random stalls, one long hold-off to back up the pipeline, one ready stretch.
    initial begin
        int cycle;
        cycle    = 0;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            cycle++;
            if (cycle >= 300 && cycle < 380) begin
                m_tready <= 1'b0;
            end else if (cycle >= 900 && cycle < 1300) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 27);
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        logic [7:0] y_first;
        logic [7:0] y_second;
        logic [7:0] cb;
        logic [7:0] cr;
        int         frame_left;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        sender_gaps = 1'b1;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed pairs: field extremes, black and white, clamping in both directions.
        send_pair(pair_word(8'h00, 8'h00, 8'h00, 8'h00), 1'b0);
        send_pair(pair_word(8'hff, 8'hff, 8'hff, 8'hff), 1'b1);
        send_pair(pair_word(8'd16, 8'd128, 8'd16, 8'd128), 1'b0);
        send_pair(pair_word(8'd235, 8'd128, 8'd235, 8'd128), 1'b0);
        send_pair(pair_word(8'hff, 8'd128, 8'hff, 8'd128), 1'b0);
        send_pair(pair_word(8'h00, 8'd128, 8'h00, 8'd128), 1'b1);
        send_pair(pair_word(8'd128, 8'h00, 8'd128, 8'hff), 1'b0);
        send_pair(pair_word(8'd128, 8'hff, 8'd128, 8'h00), 1'b0);
        send_pair(pair_word(8'd128, 8'hff, 8'd128, 8'hff), 1'b0);
        send_pair(pair_word(8'd128, 8'h00, 8'd128, 8'h00), 1'b1);
        send_pair(pair_word(8'h00, 8'd128, 8'hff, 8'd128), 1'b0);
        send_pair(pair_word(8'hff, 8'd128, 8'h00, 8'd128), 1'b0);
        send_pair(32'haa55aa55, 1'b0);
        send_pair(32'h55aa55aa, 1'b1);
        send_pair(pair_word(8'd235, 8'd240, 8'd16, 8'd16), 1'b0);
        send_pair(pair_word(8'd16, 8'd16, 8'd235, 8'd240), 1'b0);
        send_pair(pair_word(8'hff, 8'h00, 8'hff, 8'h00), 1'b0);
        send_pair(pair_word(8'h00, 8'hff, 8'h00, 8'hff), 1'b1);
        wait_drained();

        // Random frames; a mix of full-range bytes and nominal video levels.
        frame_left = $urandom_range(40, 1);
        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            if (n == 350) begin
                wait_drained();
            end
            sender_gaps = !(n >= 400 && n < 550);
            if ($urandom_range(99) < 60) begin
                {y_second, cr, y_first, cb} = $urandom;
            end else begin
                y_second = 8'($urandom_range(235, 16));
                y_first  = 8'($urandom_range(235, 16));
                cr       = 8'($urandom_range(240, 16));
                cb       = 8'($urandom_range(240, 16));
            end
            frame_left--;
            send_pair(pair_word(y_second, cr, y_first, cb), frame_left == 0);
            if (frame_left == 0) begin
                frame_left = $urandom_range(40, 1);
            end
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ yuyv_pair_to_rgb565.f @@
rtl/yuyv565_pkg.sv
rtl/yuyv565_pixel.sv
rtl/yuyv_pair_to_rgb565.sv
tb/rgb565_pair_checker.sv
tb/tb.sv
